@@ hdl/itap_pkg.sv @@
`timescale 1ns / 1ps

package itap_pkg;

   // Parser phases while one address string streams in.
   typedef enum logic [2:0] {
      PH_BEGIN        = 3'd0,
      PH_LEAD_COLON   = 3'd1,
      PH_AFTER_COLON  = 3'd2,
      PH_AFTER_DCOLON = 3'd3,
      PH_HEXTET       = 3'd4,
      PH_V4_DOT       = 3'd5,
      PH_V4_DIGIT     = 3'd6
   } itap_phase_type;

   // Configuration register indexes.
   localparam logic CSR_ALLOW_IPV4_TAIL = 1'b0;
   localparam logic CSR_EMPTY_OK        = 1'b1;

   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;

   localparam logic [3:0] GROUPS_FULL      = 4'd8;
   localparam logic [3:0] GROUPS_WITH_RUN  = 4'd7;
   localparam logic [8:0] OCTET_MAX        = 9'd255;
   localparam logic [8:0] DECIMAL_SATURATE = 9'd256;
   localparam logic [15:0] HEXTET_SHIFT_MAX = 16'h0fff;
   localparam logic [15:0] V4_MAPPED_MARK  = 16'hffff;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
      logic       empty_string;
   } itap_char_type;

   typedef struct packed {
      logic allow_ipv4_tail;
      logic empty_ok;
   } itap_cfg_type;

   typedef struct packed {
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic        addr_valid;
   } itap_result_type;

endpackage

@@ hdl/ipv6_text_address_parser.sv @@
`timescale 1ns / 1ps
// A character's transfer loads the input register; its result then loads the result register,
// once that register is free, and is presented on the response channel.
// Throughput: one character per cycle, set by the parse step in itap_parse_core;
// a character that ends a string waits while an earlier result is still stalled.
// Reset (synchronous, active high) empties both registers, clears the parse state, enables
// IPv4 tails and disables empty strings.
module ipv6_text_address_parser import itap_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_last_char,
   input  logic        req_empty_string,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_addr_high,
   output logic [63:0] rsp_addr_low,
   output logic        rsp_addr_valid,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic        csr_write_data
);

   itap_cfg_type    cfg_ff, cfg_in;
   logic            in_valid_ff, in_valid_in;
   itap_char_type   in_item_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   itap_result_type rsp_data_ff;
   itap_result_type step_result;

   logic req_transfer;
   logic needs_output;
   logic out_free;
   logic step;

   // The held character advances when it makes no result, or when the result register
   // is empty or being drained in this cycle. Characters that end no string keep
   // flowing even while a finished result waits to be taken.
   assign needs_output = in_item_ff.last_char | in_item_ff.empty_string;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign step         = in_valid_ff && (!needs_output || out_free);
   assign req_stall    = in_valid_ff && !step;
   assign req_transfer = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_transfer) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (step && needs_output) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // The user must write the registers only while the block is idle; the block does not enforce this.
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ALLOW_IPV4_TAIL: cfg_in.allow_ipv4_tail = csr_write_data;
            CSR_EMPTY_OK:        cfg_in.empty_ok        = csr_write_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   itap_parse_core u_parse_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         cfg_ff.allow_ipv4_tail <= 1'b1;
         cfg_ff.empty_ok        <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers load on their transfers and need no reset.
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         in_item_ff.char_code    <= req_char_code;
         in_item_ff.last_char    <= req_last_char;
         in_item_ff.empty_string <= req_empty_string;
      end
      if (step && needs_output) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_addr_high  = rsp_data_ff.addr_high;
   assign rsp_addr_low   = rsp_data_ff.addr_low;
   assign rsp_addr_valid = rsp_data_ff.addr_valid;

endmodule

@@ hdl/itap_parse_core.sv @@
`timescale 1ns / 1ps

module itap_parse_core import itap_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  itap_char_type   item,
   input  itap_cfg_type    cfg,
   output itap_result_type result
);

   itap_phase_type phase_ff, phase_in;
   logic [15:0] head_ff [8];
   logic [15:0] head_in [8];
   // Tail groups shift in at index 0, so the newest group sits at the address end.
   logic [15:0] tail_ff [8];
   logic [15:0] tail_in [8];
   logic [3:0]  total_ff, total_in;
   logic [15:0] gval_ff, gval_in;
   logic [8:0]  gdec_ff, gdec_in;
   logic        all_dec_ff, all_dec_in;
   logic        first_ff, first_in;
   logic        dcolon_ff, dcolon_in;
   logic [7:0]  oct_ff [3];
   logic [7:0]  oct_in [3];
   logic [1:0]  dot_ff, dot_in;
   logic        err_ff, err_in;

   logic        is_dec, is_hex, is_colon, is_dot;
   logic [3:0]  hex_val;
   logic [11:0] dec_prod;
   logic [3:0]  limit;

   // Character classification.
   always_comb begin
      is_dec   = (item.char_code >= 8'h30) && (item.char_code <= 8'h39);
      is_colon = (item.char_code == CHAR_COLON);
      is_dot   = (item.char_code == CHAR_DOT);
      is_hex   = 1'b1;
      hex_val  = 4'd0;
      if (is_dec) begin
         hex_val = item.char_code[3:0];
      end else if ((item.char_code >= 8'h61) && (item.char_code <= 8'h66)) begin
         hex_val = 4'(item.char_code - 8'h57);
      end else if ((item.char_code >= 8'h41) && (item.char_code <= 8'h46)) begin
         hex_val = 4'(item.char_code - 8'h37);
      end else begin
         is_hex = 1'b0;
      end
      dec_prod = ({3'b000, gdec_ff} * 12'd10) + {8'h00, hex_val};
      limit    = dcolon_ff ? GROUPS_WITH_RUN : GROUPS_FULL;
   end

   // Effect of one character on the parse state.
   always_comb begin
      phase_in   = phase_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      total_in   = total_ff;
      gval_in    = gval_ff;
      gdec_in    = gdec_ff;
      all_dec_in = all_dec_ff;
      first_in   = first_ff;
      dcolon_in  = dcolon_ff;
      oct_in     = oct_ff;
      dot_in     = dot_ff;
      err_in     = err_ff;
      if (!err_ff) begin
         case (phase_ff)
            PH_BEGIN, PH_AFTER_COLON, PH_AFTER_DCOLON: begin
               if (is_hex) begin
                  gval_in    = {12'h000, hex_val};
                  all_dec_in = is_dec;
                  gdec_in    = is_dec ? {5'b00000, hex_val} : 9'd0;
                  phase_in   = PH_HEXTET;
               end else if (is_colon && (phase_ff == PH_BEGIN)) begin
                  phase_in = PH_LEAD_COLON;
               end else if (is_colon && (phase_ff == PH_AFTER_COLON) && !dcolon_ff
                            && (total_ff < GROUPS_FULL)) begin
                  dcolon_in = 1'b1;
                  phase_in  = PH_AFTER_DCOLON;
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_LEAD_COLON: begin
               if (is_colon) begin
                  dcolon_in = 1'b1;
                  first_in  = 1'b0;
                  phase_in  = PH_AFTER_DCOLON;
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_HEXTET: begin
               if (is_hex) begin
                  if (gval_ff > HEXTET_SHIFT_MAX) begin
                     err_in = 1'b1;
                  end else begin
                     gval_in = {gval_ff[11:0], hex_val};
                     if (!is_dec) begin
                        all_dec_in = 1'b0;
                     end else if (all_dec_ff) begin
                        gdec_in = (dec_prod > {3'b000, OCTET_MAX}) ? DECIMAL_SATURATE
                                                                   : dec_prod[8:0];
                     end
                  end
               end else if (is_colon) begin
                  if (total_ff < limit) begin
                     if (dcolon_ff) begin
                        tail_in[0] = gval_ff;
                        for (int j = 1; j < 8; j++) begin
                           tail_in[j] = tail_ff[j-1];
                        end
                     end else begin
                        head_in[total_ff[2:0]] = gval_ff;
                     end
                     total_in = total_ff + 4'd1;
                  end else begin
                     err_in = 1'b1;
                  end
                  first_in = 1'b0;
                  phase_in = PH_AFTER_COLON;
               end else if (is_dot) begin
                  if (!cfg.allow_ipv4_tail || !all_dec_ff || (gdec_ff > OCTET_MAX)) begin
                     err_in = 1'b1;
                  end else if (!first_ff
                               && (({1'b0, total_ff} + 5'd2) > {1'b0, limit})) begin
                     err_in = 1'b1;
                  end else begin
                     oct_in[0] = gdec_ff[7:0];
                     dot_in    = 2'd1;
                     gdec_in   = 9'd0;
                     phase_in  = PH_V4_DOT;
                  end
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_V4_DOT: begin
               if (is_dec) begin
                  gdec_in  = {5'b00000, hex_val};
                  phase_in = PH_V4_DIGIT;
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_V4_DIGIT: begin
               if (is_dec) begin
                  gdec_in = dec_prod[8:0];
                  if (dec_prod > {3'b000, OCTET_MAX}) begin
                     err_in = 1'b1;
                  end
               end else if (is_dot && (dot_ff != 2'd3)) begin
                  case (dot_ff)
                     2'd0:    oct_in[0] = gdec_ff[7:0];
                     2'd1:    oct_in[1] = gdec_ff[7:0];
                     default: oct_in[2] = gdec_ff[7:0];
                  endcase
                  dot_in   = dot_ff + 2'd1;
                  gdec_in  = 9'd0;
                  phase_in = PH_V4_DOT;
               end else begin
                  err_in = 1'b1;
               end
            end
            default: begin
               err_in = 1'b1;
            end
         endcase
      end
   end

   // End of string: close the open group or IPv4 tail and lay out the address.
   logic [1:0]  fin_count;
   logic [15:0] fin_v0, fin_v1;
   logic [3:0]  fin_limit;
   logic [4:0]  fin_total;
   logic        fin_ok, fin_mapped;
   logic [31:0] fin_v4;
   logic [2:0]  fin_idx0, fin_idx1;
   logic [15:0] head_f [8];
   logic [15:0] tail_f [8];
   logic [15:0] grp [8];

   always_comb begin
      fin_count  = 2'd0;
      fin_v0     = gval_in;
      fin_v1     = {oct_in[2], gdec_in[7:0]};
      fin_limit  = dcolon_in ? GROUPS_WITH_RUN : GROUPS_FULL;
      fin_ok     = !err_in;
      fin_mapped = 1'b0;
      fin_v4     = {oct_in[0], oct_in[1], oct_in[2], gdec_in[7:0]};
      case (phase_in)
         PH_HEXTET: begin
            fin_count = 2'd1;
            if (total_in >= fin_limit) begin
               fin_ok = 1'b0;
            end
         end
         PH_AFTER_DCOLON: begin
            fin_count = 2'd0;
         end
         PH_V4_DIGIT: begin
            if (dot_in != 2'd3) begin
               fin_ok = 1'b0;
            end else if (first_in) begin
               fin_mapped = 1'b1;
            end else begin
               fin_count = 2'd2;
               fin_v0    = {oct_in[0], oct_in[1]};
               if ((total_in >= fin_limit) || ((total_in + 4'd1) >= fin_limit)) begin
                  fin_ok = 1'b0;
               end
            end
         end
         default: begin
            fin_ok = 1'b0;
         end
      endcase
      fin_total = {1'b0, total_in} + {3'b000, fin_count};
      if (!fin_mapped) begin
         if (dcolon_in ? (fin_total > {1'b0, GROUPS_WITH_RUN})
                       : (fin_total != {1'b0, GROUPS_FULL})) begin
            fin_ok = 1'b0;
         end
      end

      fin_idx0 = total_in[2:0];
      fin_idx1 = fin_idx0 + 3'd1;
      head_f   = head_in;
      tail_f   = tail_in;
      if (dcolon_in) begin
         if (fin_count == 2'd1) begin
            tail_f[0] = fin_v0;
            for (int j = 1; j < 8; j++) begin
               tail_f[j] = tail_in[j-1];
            end
         end else if (fin_count == 2'd2) begin
            tail_f[0] = fin_v1;
            tail_f[1] = fin_v0;
            for (int j = 2; j < 8; j++) begin
               tail_f[j] = tail_in[j-2];
            end
         end
      end else begin
         if (fin_count != 2'd0) begin
            head_f[fin_idx0] = fin_v0;
         end
         if (fin_count == 2'd2) begin
            head_f[fin_idx1] = fin_v1;
         end
      end
      // Unused slots of both arrays hold zero, so the zero run falls out of an OR.
      for (int j = 0; j < 8; j++) begin
         grp[j] = head_f[j] | tail_f[7-j];
      end
   end

   always_comb begin
      result.addr_high  = 64'd0;
      result.addr_low   = 64'd0;
      result.addr_valid = 1'b0;
      if (item.empty_string) begin
         result.addr_valid = cfg.empty_ok;
      end else if (fin_ok) begin
         result.addr_valid = 1'b1;
         if (fin_mapped) begin
            if (fin_v4 != 32'd0) begin
               result.addr_low = {16'h0000, V4_MAPPED_MARK, fin_v4};
            end
         end else begin
            result.addr_high = {grp[0], grp[1], grp[2], grp[3]};
            result.addr_low  = {grp[4], grp[5], grp[6], grp[7]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && (item.empty_string || item.last_char))) begin
         phase_ff   <= PH_BEGIN;
         total_ff   <= 4'd0;
         gval_ff    <= 16'd0;
         gdec_ff    <= 9'd0;
         all_dec_ff <= 1'b1;
         first_ff   <= 1'b1;
         dcolon_ff  <= 1'b0;
         dot_ff     <= 2'd0;
         err_ff     <= 1'b0;
         for (int j = 0; j < 8; j++) begin
            head_ff[j] <= 16'd0;
            tail_ff[j] <= 16'd0;
         end
         for (int j = 0; j < 3; j++) begin
            oct_ff[j] <= 8'd0;
         end
      end else if (step) begin
         phase_ff   <= phase_in;
         total_ff   <= total_in;
         gval_ff    <= gval_in;
         gdec_ff    <= gdec_in;
         all_dec_ff <= all_dec_in;
         first_ff   <= first_in;
         dcolon_ff  <= dcolon_in;
         dot_ff     <= dot_in;
         err_ff     <= err_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         oct_ff     <= oct_in;
      end
   end

endmodule

@@ tb/ipv6_text_address_parser_test.sv @@
`timescale 1ns / 1ps

// Self-checking testbench for the IPv6 text address parser. An initial block queues address
// strings one character per entry. A clocked driver presents them on the request channel, and
// at every request transfer a model of the parser updates its own parse state. At the last
// character of a string, or at an empty-string item, the model queues the address that the
// block must return. A clocked monitor takes each response transfer and checks it, field by
// field, against the oldest queued address.
module ipv6_text_address_parser_test;
   import itap_pkg::*;

   localparam int CLOCK_HIGH_NS = 4;
   localparam int CLOCK_LOW_NS  = 4;
   localparam int RESET_CYCLES  = 4;
   // Cycle limit for the watchdog, chosen to leave a wide margin over the slowest run.
   localparam int CYCLE_LIMIT   = 200000;
   // The block holds at most a character in its input register and a result in its result
   // register, and these cycles let it go quiet once the last result has been taken.
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_PHASES = 9;
   localparam int RANDOM_CHARS  = 1500;

   localparam logic [7:0] CH_ZERO    = "0";
   localparam logic [7:0] CH_NINE    = "9";
   localparam logic [7:0] CH_LOWER_A = "a";
   localparam logic [7:0] CH_LOWER_F = "f";
   localparam logic [7:0] CH_UPPER_A = "A";
   localparam logic [7:0] CH_UPPER_F = "F";
   localparam logic [7:0] CH_LOWER_G = "g";

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code    = 8'h00;
   logic        req_last_char    = 1'b0;
   logic        req_empty_string = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [63:0] rsp_addr_high;
   logic [63:0] rsp_addr_low;
   logic        rsp_addr_valid;
   logic        csr_write_enable = 1'b0;
   logic        csr_index        = CSR_ALLOW_IPV4_TAIL;
   logic        csr_write_data   = 1'b0;

   ipv6_text_address_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_last_char    (req_last_char),
      .req_empty_string (req_empty_string),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_addr_high    (rsp_addr_high),
      .rsp_addr_low     (rsp_addr_low),
      .rsp_addr_valid   (rsp_addr_valid),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #CLOCK_LOW_NS clock = 1'b1;
      #CLOCK_HIGH_NS clock = 1'b0;
   end

   // Characters waiting to be sent, addresses waiting to be received, and the text of the
   // string that is being built before it is queued.
   itap_char_type   pending_chars[$];
   itap_result_type expected_addresses[$];
   logic [7:0]      text_bytes[$];

   int sender_idle_pct    = 20;
   int receiver_stall_pct = 83;
   int mismatch_count     = 0;
   int cycle_count        = 0;
   int chars_queued       = 0;

   // Mirror of the configuration registers, starting from their reset values.
   logic cfg_ipv4_tail = 1'b1;
   logic cfg_empty_ok  = 1'b0;

   // Parse state of the model.
   itap_phase_type scan_phase;
   logic [15:0]    lead_hextets[8];
   logic [15:0]    trail_hextets[8];
   int unsigned    lead_count;
   int unsigned    trail_count;
   int unsigned    group_tally;
   int unsigned    hextet_value;
   int unsigned    decimal_value;
   int unsigned    ipv4_octets[3];
   int unsigned    dot_seen;
   logic           all_decimal;
   logic           no_colon_yet;
   logic           have_zero_run;
   logic           broken;

   function automatic void clear_scan();
      scan_phase = PH_BEGIN;
      for (int i = 0; i < 8; i++) begin
         lead_hextets[i]  = '0;
         trail_hextets[i] = '0;
      end
      for (int i = 0; i < 3; i++) ipv4_octets[i] = 0;
      lead_count    = 0;
      trail_count   = 0;
      group_tally   = 0;
      hextet_value  = 0;
      decimal_value = 0;
      dot_seen      = 0;
      all_decimal   = 1'b1;
      no_colon_yet  = 1'b1;
      have_zero_run = 1'b0;
      broken        = 1'b0;
   endfunction

   // Value of a hex digit, or -1 for any other character.
   function automatic int hex_nibble(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c) - int'(CH_ZERO);
      if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c) - int'(CH_LOWER_A) + 10;
      if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c) - int'(CH_UPPER_A) + 10;
      return -1;
   endfunction

   // A zero run takes the place of at least one group, so at most seven may be written.
   function automatic int unsigned hextet_limit();
      return have_zero_run ? 32'(GROUPS_WITH_RUN) : 32'(GROUPS_FULL);
   endfunction

   function automatic void store_hextet(int unsigned v);
      if (group_tally >= hextet_limit()) begin
         broken = 1'b1;
         return;
      end
      if (have_zero_run) begin
         trail_hextets[trail_count % 8] = v[15:0];
         trail_count++;
      end else begin
         lead_hextets[lead_count % 8] = v[15:0];
         lead_count++;
      end
      group_tally++;
   endfunction

   function automatic void open_hextet(int unsigned d);
      hextet_value  = d;
      all_decimal   = d < 10;
      decimal_value = (d < 10) ? d : 0;
      scan_phase    = PH_HEXTET;
   endfunction

   function automatic void scan_char(logic [7:0] c);
      int d;
      d = hex_nibble(c);
      case (scan_phase)
         PH_BEGIN: begin
            if (c == CHAR_COLON) scan_phase = PH_LEAD_COLON;
            else if (d >= 0) open_hextet(d);
            else broken = 1'b1;
         end
         PH_LEAD_COLON: begin
            // A leading colon is only legal as the start of a zero run.
            if (c == CHAR_COLON) begin
               have_zero_run = 1'b1;
               no_colon_yet  = 1'b0;
               scan_phase    = PH_AFTER_DCOLON;
            end else broken = 1'b1;
         end
         PH_AFTER_COLON: begin
            if (d >= 0) open_hextet(d);
            else if (c == CHAR_COLON && !have_zero_run && group_tally < GROUPS_FULL) begin
               have_zero_run = 1'b1;
               scan_phase    = PH_AFTER_DCOLON;
            end else broken = 1'b1;
         end
         PH_AFTER_DCOLON: begin
            if (d >= 0) open_hextet(d);
            else broken = 1'b1;
         end
         PH_HEXTET: begin
            if (d >= 0) begin
               // Leading zeros are fine, but the value may never pass 0xffff.
               if (hextet_value > HEXTET_SHIFT_MAX) broken = 1'b1;
               else begin
                  hextet_value = (hextet_value << 4) | d;
                  if (d >= 10) all_decimal = 1'b0;
                  else if (all_decimal) begin
                     decimal_value = decimal_value * 10 + d;
                     if (decimal_value > OCTET_MAX) decimal_value = 32'(DECIMAL_SATURATE);
                  end
               end
            end else if (c == CHAR_COLON) begin
               store_hextet(hextet_value);
               no_colon_yet = 1'b0;
               scan_phase   = PH_AFTER_COLON;
            end else if (c == CHAR_DOT) begin
               // The group read so far turns out to be the first octet of an IPv4 part.
               if (!cfg_ipv4_tail || !all_decimal || decimal_value > OCTET_MAX) broken = 1'b1;
               else if (!no_colon_yet && group_tally + 2 > hextet_limit()) broken = 1'b1;
               else begin
                  ipv4_octets[0] = decimal_value;
                  dot_seen       = 1;
                  decimal_value  = 0;
                  scan_phase     = PH_V4_DOT;
               end
            end else broken = 1'b1;
         end
         PH_V4_DOT: begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
               decimal_value = int'(c) - int'(CH_ZERO);
               scan_phase    = PH_V4_DIGIT;
            end else broken = 1'b1;
         end
         PH_V4_DIGIT: begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
               decimal_value = decimal_value * 10 + (int'(c) - int'(CH_ZERO));
               if (decimal_value > OCTET_MAX) broken = 1'b1;
            end else if (c == CHAR_DOT && dot_seen < 3) begin
               ipv4_octets[dot_seen] = decimal_value;
               dot_seen++;
               decimal_value = 0;
               scan_phase    = PH_V4_DOT;
            end else broken = 1'b1;
         end
         default: broken = 1'b1;
      endcase
   endfunction

   // Completes the string at its last character; returns 1 when the text is an address.
   function automatic bit close_scan(output logic [63:0] hi, output logic [63:0] lo);
      logic [15:0] g[8];
      logic [31:0] v4;
      hi = '0;
      lo = '0;
      if (broken) return 1'b0;
      case (scan_phase)
         PH_HEXTET: store_hextet(hextet_value);
         PH_AFTER_DCOLON: ;
         PH_V4_DIGIT: begin
            if (dot_seen != 3) return 1'b0;
            if (no_colon_yet) begin
               // Plain IPv4 maps to ::ffff:a.b.c.d, except that 0.0.0.0 stays all zero.
               v4 = (ipv4_octets[0] << 24) | (ipv4_octets[1] << 16) |
                    (ipv4_octets[2] << 8) | decimal_value;
               if (v4 != 0) lo = {16'h0000, V4_MAPPED_MARK, v4};
               return 1'b1;
            end
            store_hextet((ipv4_octets[0] << 8) | ipv4_octets[1]);
            store_hextet((ipv4_octets[2] << 8) | decimal_value);
         end
         default: return 1'b0;
      endcase
      if (broken) return 1'b0;
      if (have_zero_run ? group_tally > GROUPS_WITH_RUN : group_tally != GROUPS_FULL)
         return 1'b0;
      for (int i = 0; i < 8; i++) g[i] = '0;
      for (int i = 0; i < lead_count && i < 8; i++) g[i] = lead_hextets[i];
      // Groups after the zero run are right-aligned at the end of the address.
      for (int i = 0; i < trail_count && i < 8; i++)
         g[(8 - trail_count + i) % 8] = trail_hextets[i];
      hi = {g[0], g[1], g[2], g[3]};
      lo = {g[4], g[5], g[6], g[7]};
      return 1'b1;
   endfunction

   // Applies one transferred character to the model and queues the address it completes.
   function automatic void parse_address_char(itap_char_type item);
      itap_result_type addr;
      logic [63:0]     hi;
      logic [63:0]     lo;
      bit              ok;
      if (item.empty_string) begin
         // An empty-string item drops any partial text and answers on its own.
         clear_scan();
         addr.addr_high  = '0;
         addr.addr_low   = '0;
         addr.addr_valid = cfg_empty_ok;
         expected_addresses.push_back(addr);
         return;
      end
      if (!broken) scan_char(item.char_code);
      if (item.last_char) begin
         ok = close_scan(hi, lo);
         addr.addr_high  = ok ? hi : '0;
         addr.addr_low   = ok ? lo : '0;
         addr.addr_valid = ok;
         expected_addresses.push_back(addr);
         clear_scan();
      end
   endfunction

   // Request driver. A character is predicted at the edge where its transfer happens; a new
   // one is loaded only when the channel is free, so a stalled character never changes.
   always @(posedge clock) begin : char_driver
      itap_char_type next_char;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            parse_address_char(itap_char_type'({req_char_code, req_last_char, req_empty_string}));
         if (!req_valid || !req_stall) begin
            if (pending_chars.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_char = pending_chars.pop_front();
               req_valid        <= 1'b1;
               req_char_code    <= next_char.char_code;
               req_last_char    <= next_char.last_char;
               req_empty_string <= next_char.empty_string;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. The stall is redrawn every cycle, independent of rsp_valid.
   always @(posedge clock) begin : address_monitor
      itap_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_addresses.size() == 0) begin
               $error("unexpected result transfer: addr_high=%h addr_low=%h addr_valid=%b",
                      rsp_addr_high, rsp_addr_low, rsp_addr_valid);
               mismatch_count++;
            end else begin
               want = expected_addresses.pop_front();
               if (rsp_addr_high !== want.addr_high) begin
                  $error("addr_high: expected %h, actual %h", want.addr_high, rsp_addr_high);
                  mismatch_count++;
               end
               if (rsp_addr_low !== want.addr_low) begin
                  $error("addr_low: expected %h, actual %h", want.addr_low, rsp_addr_low);
                  mismatch_count++;
               end
               if (rsp_addr_valid !== want.addr_valid) begin
                  $error("addr_valid: expected %b, actual %b", want.addr_valid,
                         rsp_addr_valid);
                  mismatch_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [7:0] digit_char(int n);
      return 8'(int'(CH_ZERO) + n);
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 10) return digit_char(n);
      if ($urandom_range(1) == 1) return 8'(int'(CH_LOWER_A) + int'(n) - 10);
      return 8'(int'(CH_UPPER_A) + int'(n) - 10);
   endfunction

   // Characters that sit near the edge of the grammar, with an arbitrary byte now and then.
   function automatic logic [7:0] noise_char();
      case ($urandom_range(5))
         0:       return CHAR_COLON;
         1:       return CHAR_DOT;
         2:       return CH_LOWER_G;
         3:       return 8'($urandom_range(255));
         default: return hex_char(4'($urandom_range(15)));
      endcase
   endfunction

   task automatic push_char(input logic [7:0] code, input logic last, input logic empty);
      itap_char_type c;
      c.char_code    = code;
      c.last_char    = last;
      c.empty_string = empty;
      pending_chars.push_back(c);
   endtask

   // Waits until every character has been sent and every address received, then lets the
   // block go quiet. Configuration writes and the end of the run come only after this.
   task automatic wait_idle();
      while (pending_chars.size() != 0 || req_valid || expected_addresses.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Queues the built text as one string. A nonzero pause_at holds the sender back in the
   // middle of the string until all outstanding addresses have come back.
   task automatic push_text(input int pause_at);
      for (int i = 0; i < text_bytes.size(); i++) begin
         if (pause_at > 0 && i == pause_at) wait_idle();
         push_char(text_bytes[i], i == text_bytes.size() - 1, 1'b0);
      end
      chars_queued += text_bytes.size();
      text_bytes.delete();
   endtask

   task automatic add_literal(input string s);
      for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
   endtask

   task automatic write_csr(input logic index, input logic data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      if (index == CSR_ALLOW_IPV4_TAIL) cfg_ipv4_tail = data;
      else cfg_empty_ok = data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // One hex group, biased toward zero and 0xffff, sometimes with leading zeros.
   task automatic add_hextet();
      logic [15:0] v;
      int          digits;
      int          pad;
      case ($urandom_range(3))
         0:       v = 16'h0000;
         1:       v = 16'hffff;
         2:       v = 16'($urandom_range(255));
         default: v = 16'($urandom);
      endcase
      digits = (v > 16'h0fff) ? 4 : (v > 16'h00ff) ? 3 : (v > 16'h000f) ? 2 : 1;
      pad = ($urandom_range(9) == 0) ? $urandom_range(5 - digits, 1) : 0;
      repeat (pad) text_bytes.push_back(CH_ZERO);
      for (int i = digits - 1; i >= 0; i--) text_bytes.push_back(hex_char(v[i*4 +: 4]));
   endtask

   // One decimal octet; now and then out of range or with a leading zero.
   task automatic add_octet();
      int v;
      case ($urandom_range(11))
         0:       v = 0;
         1:       v = 255;
         2:       v = $urandom_range(999, 256);
         default: v = $urandom_range(255);
      endcase
      if ($urandom_range(9) == 0) text_bytes.push_back(CH_ZERO);
      if (v >= 100) text_bytes.push_back(digit_char(v / 100));
      if (v >= 10) text_bytes.push_back(digit_char((v / 10) % 10));
      text_bytes.push_back(digit_char(v % 10));
   endtask

   task automatic add_ipv4();
      add_octet();
      repeat (3) begin
         text_bytes.push_back(CHAR_DOT);
         add_octet();
      end
   endtask

   // Writes n groups separated by colons; with v4_tail the last two become dotted decimal.
   task automatic add_group_list(input int n, input bit v4_tail);
      int hex_groups;
      hex_groups = v4_tail ? n - 2 : n;
      for (int i = 0; i < hex_groups; i++) begin
         if (i > 0) text_bytes.push_back(CHAR_COLON);
         add_hextet();
      end
      if (v4_tail) begin
         if (hex_groups > 0) text_bytes.push_back(CHAR_COLON);
         add_ipv4();
      end
   endtask

   // Builds an address of one of the three shapes, with random content; now and then it is not well formed.
   task automatic build_address();
      int n;
      int head;
      int shape;
      bit v4_tail;
      shape = $urandom_range(99);
      if (shape < 40) begin
         add_group_list(8, $urandom_range(3) == 0);
      end else if (shape < 80) begin
         // A zero run; a tenth of the time one group too many for it to be legal.
         n = ($urandom_range(9) == 0) ? 8 : $urandom_range(7);
         head = $urandom_range(n);
         v4_tail = (n - head >= 2) && ($urandom_range(3) == 0);
         add_group_list(head, 1'b0);
         text_bytes.push_back(CHAR_COLON);
         text_bytes.push_back(CHAR_COLON);
         add_group_list(n - head, v4_tail);
      end else begin
         add_ipv4();
      end
   endtask

   // Breaks a built string in one place: a new byte, a stray separator, a lost character
   // or an extra hex digit.
   task automatic corrupt_text();
      int pos;
      pos = $urandom_range(text_bytes.size() - 1);
      case ($urandom_range(3))
         0: text_bytes[pos] = 8'($urandom_range(255));
         1: text_bytes[pos] = ($urandom_range(1) == 1) ? CHAR_COLON : CHAR_DOT;
         2: if (text_bytes.size() > 1) text_bytes.delete(pos);
         default: text_bytes.insert(pos, hex_char(4'($urandom_range(15))));
      endcase
   endtask

   initial begin : stimulus
      int pick;
      int cut;
      bit pause_next;
      clear_scan();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed strings under the reset configuration. An empty-string item while empty
      // strings are not allowed, with the largest character code riding along unused.
      push_char(8'hff, 1'b1, 1'b1);
      // A lone colon, the bare zero run, the largest group before a run.
      add_literal(":");
      push_text(0);
      add_literal("::");
      push_text(0);
      add_literal("ffff::");
      push_text(0);
      // The all-zero IPv4 address is not mapped.
      add_literal("0.0.0.0");
      push_text(0);
      // A NUL byte makes the string invalid and everything up to its end is skipped.
      text_bytes.push_back(8'h00);
      add_literal("::");
      push_text(0);
      // A string that ends in a single colon.
      add_literal("::1:");
      push_text(0);
      wait_idle();

      // Random phases. Each sets both registers, so every combination is seen, and the
      // handshake idling goes from a lazy receiver to a lazy sender and then to none.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p / 3)
            0: begin
               sender_idle_pct    = 20;
               receiver_stall_pct = 83;
            end
            1: begin
               sender_idle_pct    = 83;
               receiver_stall_pct = 20;
            end
            default: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
         endcase
         write_csr(CSR_ALLOW_IPV4_TAIL, (p % 3) != 1);
         write_csr(CSR_EMPTY_OK, (p % 2) == 1);
         chars_queued = 0;
         pause_next = 1'b1;
         while (chars_queued < RANDOM_CHARS / RANDOM_PHASES) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
               push_char(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
               chars_queued++;
            end else if (pick < 10) begin
               // A string cut short by an empty-string item.
               build_address();
               cut = $urandom_range(text_bytes.size() - 1);
               for (int i = 0; i < cut; i++) push_char(text_bytes[i], 1'b0, 1'b0);
               push_char(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
               chars_queued += cut + 1;
               text_bytes.delete();
            end else if (pick < 22) begin
               repeat ($urandom_range(8, 1)) text_bytes.push_back(noise_char());
               push_text(0);
            end else begin
               build_address();
               if ($urandom_range(99) < 15) corrupt_text();
               // The first address of a phase is held halfway until the block drains.
               push_text(pause_next ? text_bytes.size() / 2 : 0);
               pause_next = 1'b0;
            end
         end
         wait_idle();
      end

      if (mismatch_count == 0 && expected_addresses.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
